// ----- sv/euv_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder unwrap/velocity package
// Shared constants, codes and types of the multiturn angle unwrap block.
// ----------------------------------------------------------------------------
package euv_pkg;

   // Default sizes of the angle and turn counter fields.
   localparam int ANGLE_BITS_DEF = 12;
   localparam int TURN_BITS_DEF  = 24;

   // Fixed field widths.
   localparam int THR_W    = 12;
   localparam int PERIOD_W = 20;
   localparam int TIME_W   = 32;
   localparam int VEL_W    = 32;
   localparam int POS_W    = 36;

   // Microseconds per second, and the width it takes.
   localparam int unsigned US_PER_SEC = 1000000;
   localparam int          US_W       = 20;

   // Velocity saturation limits (magnitudes).
   localparam logic [VEL_W-1:0] VEL_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [VEL_W-1:0] VEL_NEG_MAG = 32'h8000_0000;

   // Register reset values.
   localparam logic [THR_W-1:0]    THR_RESET    = 12'd3276;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JUMP_THRESHOLD = 2'd0,
      CSR_DEFAULT_PERIOD = 2'd1
   } csr_index_type;

   // Command queue between the front and back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef enum logic [0:0] {
      OP_SAMPLE   = 1'b0,
      OP_VELOCITY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_DIV,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [THR_W-1:0]    jump_threshold;
      logic [PERIOD_W-1:0] default_period_us;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- sv/euv_front.sv -----
// ----------------------------------------------------------------------------
// Encoder unwrap/velocity front end
// Takes requests, classifies them into sample or velocity commands and
// hands them to the command queue.
// ----------------------------------------------------------------------------
module euv_front
   import euv_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [ANGLE_BITS-1:0]         req_raw_angle,
   input  logic [TIME_W-1:0]             req_timestamp_us,
   input  q_status_type                  q_status,
   output logic                          q_push,
   output logic [1+ANGLE_BITS+TIME_W-1:0] q_data
);

   localparam int CMD_W = 1 + ANGLE_BITS + TIME_W;

   logic             slot_valid_ff, slot_valid_in;
   logic [CMD_W-1:0] slot_cmd_ff, slot_cmd_in;
   logic             accept;
   op_type           op;

   assign q_push    = slot_valid_ff && !q_status.full;
   assign req_stall = slot_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_data    = slot_cmd_ff;

   always_comb begin
      op            = req_mode ? OP_VELOCITY : OP_SAMPLE;
      slot_valid_in = accept || (slot_valid_ff && !q_push);
      slot_cmd_in   = slot_cmd_ff;
      if (accept) begin
         // Velocity requests carry no angle or time: drop them.
         if (op == OP_VELOCITY) begin
            slot_cmd_in = {op, {ANGLE_BITS{1'b0}}, {TIME_W{1'b0}}};
         end else begin
            slot_cmd_in = {op, req_raw_angle, req_timestamp_us};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_cmd_ff <= slot_cmd_in;
   end

endmodule

// ----- sv/euv_queue.sv -----
// ----------------------------------------------------------------------------
// Encoder unwrap/velocity command queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module euv_queue
   import euv_pkg::*;
#(
   parameter int DATA_W = 1 + ANGLE_BITS_DEF + TIME_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output q_status_type      status
);

   logic [DATA_W-1:0]  entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/euv_back.sv -----
// ----------------------------------------------------------------------------
// Encoder unwrap/velocity back end
// Holds the angle/turn state, unwraps samples, and computes velocity with a
// constant multiply and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module euv_back
   import euv_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int TURN_BITS  = TURN_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  q_status_type                   q_status,
   input  logic [1+ANGLE_BITS+TIME_W-1:0] q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ANGLE_BITS-1:0]          rsp_angle_counts,
   output logic signed [TURN_BITS-1:0]    rsp_turn_count,
   output logic signed [POS_W-1:0]        rsp_position_counts,
   output logic signed [VEL_W-1:0]        rsp_velocity_cps
);

   localparam int CMD_W  = 1 + ANGLE_BITS + TIME_W;
   localparam int MAG_W  = TURN_BITS + ANGLE_BITS;
   localparam int DPOS_W = MAG_W + 1;
   localparam int NUM_W  = MAG_W + US_W;
   localparam int HALF_W = (MAG_W + 1) / 2;
   localparam int REST_W = MAG_W - HALF_W;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int CMP_W  = (ANGLE_BITS > THR_W) ? ANGLE_BITS : THR_W;

   back_state_type state_ff, state_in;

   // Architectural state.
   logic [ANGLE_BITS-1:0] last_angle_ff, last_angle_in;
   logic [TURN_BITS-1:0]  turns_ff, turns_in;
   logic [TIME_W-1:0]     last_time_ff, last_time_in;
   logic [ANGLE_BITS-1:0] ref_angle_ff, ref_angle_in;
   logic [TURN_BITS-1:0]  ref_turns_ff, ref_turns_in;
   logic [TIME_W-1:0]     ref_time_ff, ref_time_in;

   // Velocity datapath.
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [TIME_W-1:0] dt_ff, dt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_BITS-1:0] rsp_angle_ff, rsp_angle_in;
   logic [TURN_BITS-1:0]  rsp_turns_ff, rsp_turns_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [VEL_W-1:0]      rsp_vel_ff, rsp_vel_in;

   op_type                cmd_op;
   logic [ANGLE_BITS-1:0] cmd_angle;
   logic [TIME_W-1:0]     cmd_time;

   logic                  out_free;
   logic                  jump_up;
   logic [ANGLE_BITS-1:0] jump_mag;
   logic [TURN_BITS-1:0]  turns_step;
   logic [TURN_BITS-1:0]  dturn;
   logic [ANGLE_BITS:0]   dangle;
   logic [DPOS_W-1:0]     dpos;
   logic [DPOS_W-1:0]     mag_full;
   logic [TIME_W-1:0]     dt_raw;
   logic [TIME_W-1:0]     dt_sel;
   logic [HALF_W+US_W-1:0] lo_prod;
   logic [REST_W+US_W-1:0] hi_prod;
   logic [TIME_W:0]       trial;
   logic [TIME_W:0]       trial_diff;
   logic                  trial_ge;
   logic [VEL_W-1:0]      q_pos;
   logic [VEL_W-1:0]      q_neg;
   logic [VEL_W-1:0]      vel_sat;

   assign cmd_op    = op_type'(q_data[CMD_W-1]);
   assign cmd_angle = q_data[TIME_W +: ANGLE_BITS];
   assign cmd_time  = q_data[TIME_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Wrap detection on a new sample.
   always_comb begin
      jump_up  = cmd_angle > last_angle_ff;
      jump_mag = jump_up ? (cmd_angle - last_angle_ff) : (last_angle_ff - cmd_angle);
      turns_step = turns_ff;
      if (CMP_W'(jump_mag) > CMP_W'(cfg.jump_threshold)) begin
         turns_step = jump_up ? (turns_ff - 1'b1) : (turns_ff + 1'b1);
      end
   end

   // Position change and elapsed time since the reference.
   always_comb begin
      dturn    = turns_ff - ref_turns_ff;
      dangle   = {1'b0, last_angle_ff} - {1'b0, ref_angle_ff};
      dpos     = {dturn[TURN_BITS-1], dturn, {ANGLE_BITS{1'b0}}}
               + {{(DPOS_W-ANGLE_BITS-1){dangle[ANGLE_BITS]}}, dangle};
      mag_full = dpos[DPOS_W-1] ? (~dpos + 1'b1) : dpos;
      dt_raw   = last_time_ff - ref_time_ff;
      if (dt_raw != '0) begin
         dt_sel = dt_raw;
      end else if (cfg.default_period_us != '0) begin
         dt_sel = TIME_W'(cfg.default_period_us);
      end else begin
         dt_sel = TIME_W'(1);
      end
   end

   // Magnitude times one million, split in two partial products.
   assign lo_prod = (HALF_W+US_W)'(mag_ff[HALF_W-1:0]) * (HALF_W+US_W)'(US_PER_SEC);
   assign hi_prod = (REST_W+US_W)'(mag_ff[MAG_W-1:HALF_W]) * (REST_W+US_W)'(US_PER_SEC);

   // One restoring division step.
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, dt_ff};
   assign trial_ge   = trial >= {1'b0, dt_ff};

   // Saturate the quotient into the signed 32-bit range.
   always_comb begin
      q_pos   = (num_ff > NUM_W'(VEL_POS_MAX)) ? VEL_POS_MAX : num_ff[VEL_W-1:0];
      q_neg   = (num_ff > NUM_W'(VEL_NEG_MAG)) ? VEL_NEG_MAG : num_ff[VEL_W-1:0];
      vel_sat = neg_ff ? (~q_neg + VEL_W'(1)) : q_pos;
   end

   always_comb begin
      state_in      = state_ff;
      last_angle_in = last_angle_ff;
      turns_in      = turns_ff;
      last_time_in  = last_time_ff;
      ref_angle_in  = ref_angle_ff;
      ref_turns_in  = ref_turns_ff;
      ref_time_in   = ref_time_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      dt_in         = dt_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      q_pop         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_angle_in  = rsp_angle_ff;
      rsp_turns_in  = rsp_turns_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vel_in    = rsp_vel_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty && out_free) begin
               q_pop = 1'b1;
               if (cmd_op == OP_SAMPLE) begin
                  last_angle_in = cmd_angle;
                  last_time_in  = cmd_time;
                  turns_in      = turns_step;
                  rsp_valid_in  = 1'b1;
                  rsp_vel_in    = '0;
               end else begin
                  mag_in       = mag_full[MAG_W-1:0];
                  neg_in       = dpos[DPOS_W-1];
                  dt_in        = dt_sel;
                  ref_angle_in = last_angle_ff;
                  ref_turns_in = turns_ff;
                  ref_time_in  = last_time_ff;
                  state_in     = BK_MUL_LO;
               end
            end
         end
         BK_MUL_LO: begin
            num_in   = NUM_W'(lo_prod);
            state_in = BK_MUL_HI;
         end
         BK_MUL_HI: begin
            num_in   = num_ff + (NUM_W'(hi_prod) << HALF_W);
            rem_in   = '0;
            cnt_in   = CNT_W'(NUM_W - 1);
            state_in = BK_DIV;
         end
         BK_DIV: begin
            rem_in = trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
            num_in = {num_ff[NUM_W-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_vel_in   = vel_sat;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // Load position fields from the updated state along with the result.
      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         rsp_angle_in = last_angle_in;
         rsp_turns_in = turns_in;
         rsp_pos_in   = POS_W'($signed({turns_in, last_angle_in}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_angle_ff <= '0;
         turns_ff      <= '0;
         last_time_ff  <= '0;
         ref_angle_ff  <= '0;
         ref_turns_ff  <= '0;
         ref_time_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_angle_ff <= last_angle_in;
         turns_ff      <= turns_in;
         last_time_ff  <= last_time_in;
         ref_angle_ff  <= ref_angle_in;
         ref_turns_ff  <= ref_turns_in;
         ref_time_ff   <= ref_time_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      dt_ff        <= dt_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_turns_ff <= rsp_turns_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_vel_ff   <= rsp_vel_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_angle_counts    = rsp_angle_ff;
   assign rsp_turn_count      = $signed(rsp_turns_ff);
   assign rsp_position_counts = $signed(rsp_pos_ff);
   assign rsp_velocity_cps    = $signed(rsp_vel_ff);

endmodule

// ----- sv/encoder_turn_unwrap_velocity.sv -----
// ----------------------------------------------------------------------------
// Encoder turn unwrap and velocity
// Multiturn tracking of an absolute rotary encoder angle with a velocity
// estimate in counts per second.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: mode 0 is an angle sample (raw_angle and
//   timestamp_us), mode 1 asks for the velocity since the last such request.
//   rsp_* returns one result per request, in order: latest angle, turn count,
//   multiturn position and (for mode 1 only) the saturated velocity.
//   csr_* writes the jump threshold (index 0) and default period (index 1);
//   csr_ready is always high. Write only while no request is in flight.
// Flow:
//   A sample passes the front register, the queue and the result register; the
//   back end handles one per cycle while the result is not stalled. A velocity
//   request holds the back end: capture, a low and a high partial product of
//   the multiply by one million, the restoring divider at one quotient bit per
//   cycle, and the result load. The divider sets the velocity rate.
// Reset clears the turn state, references, queue and result register and
//   loads the register defaults. When rsp_stall is high the result holds;
//   the two-entry queue and front register keep taking requests until full.
// ----------------------------------------------------------------------------
module encoder_turn_unwrap_velocity
   import euv_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int TURN_BITS  = TURN_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [ANGLE_BITS-1:0]       req_raw_angle,
   input  logic [TIME_W-1:0]           req_timestamp_us,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ANGLE_BITS-1:0]       rsp_angle_counts,
   output logic signed [TURN_BITS-1:0] rsp_turn_count,
   output logic signed [POS_W-1:0]     rsp_position_counts,
   output logic signed [VEL_W-1:0]     rsp_velocity_cps,
   // Configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CMD_W = 1 + ANGLE_BITS + TIME_W;

   // Configuration registers.
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   cfg_type             cfg;

   // Front to queue to back.
   logic             q_push;
   logic             q_pop;
   logic [CMD_W-1:0] q_push_data;
   logic [CMD_W-1:0] q_pop_data;
   q_status_type     q_status;

   assign csr_ready = 1'b1;

   // Decode the write index; drop writes to unknown indexes.
   always_comb begin
      thr_in    = thr_ff;
      period_in = period_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_JUMP_THRESHOLD: thr_in    = csr_wdata[THR_W-1:0];
            CSR_DEFAULT_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         period_ff <= PERIOD_RESET;
      end else begin
         thr_ff    <= thr_in;
         period_ff <= period_in;
      end
   end

   assign cfg.jump_threshold    = thr_ff;
   assign cfg.default_period_us = period_ff;

   // Classify and register incoming requests.
   euv_front #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_raw_angle    (req_raw_angle),
      .req_timestamp_us (req_timestamp_us),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   // Decouple the front from the long velocity computation.
   euv_queue #(
      .DATA_W (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Unwrap, velocity and the result register.
   euv_back #(
      .ANGLE_BITS (ANGLE_BITS),
      .TURN_BITS  (TURN_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .q_status            (q_status),
      .q_data              (q_pop_data),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_angle_counts    (rsp_angle_counts),
      .rsp_turn_count      (rsp_turn_count),
      .rsp_position_counts (rsp_position_counts),
      .rsp_velocity_cps    (rsp_velocity_cps)
   );

   // Never push into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("command pushed into full queue");

   // Never pop an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("command popped from empty queue");

   // No result right after reset.
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
